>>> hdl/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// No dependencies; every other file imports this package.
package cbm_pkg;

  localparam int unsigned RAM_BYTES = 8192;
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ROM_ADDR_W = 21;
  localparam int unsigned OFFSET_W   = 14;
  localparam int unsigned LOW_BANK_W = 5;
  localparam int unsigned HIGH_BANK_W = 2;

  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;
  localparam logic        CFG_KEY_IDX = 1'b0;

  localparam logic [BYTE_W-1:0]     KEY_RESET      = 8'd10;
  localparam logic [BYTE_W-1:0]     OPEN_BUS       = 8'hFF;
  localparam logic [LOW_BANK_W-1:0] LOW_BANK_RESET = 5'd1;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    RGN_RAM_ENABLE = 3'd0,
    RGN_LOW_BANK   = 3'd1,
    RGN_HIGH_BANK  = 3'd2,
    RGN_MODE       = 3'd3,
    RGN_VIDEO      = 3'd4,
    RGN_CART_RAM   = 3'd5,
    RGN_WORK_RAM   = 3'd6,
    RGN_TOP        = 3'd7
  } region_e;

  typedef struct packed {
    logic                  ram_rd;
    logic                  fetch;
    logic [ROM_ADDR_W-1:0] rom_address;
  } stage_t;

endpackage

>>> hdl/cbm_req_if.sv
// Request channel: one bus access per beat.
// Depends on cbm_pkg for field widths.
interface cbm_req_if import cbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] bus_address;
  logic [BYTE_W-1:0] write_byte;

  modport source (output valid, opcode, bus_address, write_byte, input ready);
  modport sink   (input valid, opcode, bus_address, write_byte, output ready);
endinterface

>>> hdl/cbm_rsp_if.sv
// Response channel: one result per accepted access.
// Depends on cbm_pkg for field widths.
interface cbm_rsp_if import cbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BYTE_W-1:0]     read_byte;
  logic                  rom_fetch;
  logic [ROM_ADDR_W-1:0] rom_address;

  modport source (output valid, read_byte, rom_fetch, rom_address, input ready);
  modport sink   (input valid, read_byte, rom_fetch, rom_address, output ready);
endinterface

>>> hdl/cartridge_bank_mapper_unit.sv
// Cartridge bank controller: bank registers, ROM address map, cartridge RAM.
// Depends on cbm_pkg, cbm_req_if and cbm_rsp_if.
//
//   port    dir  kind            beat
//   req_i   in   valid/ready     opcode, bus_address, write_byte
//   rsp_o   out  valid/ready     read_byte, rom_fetch, rom_address
//   apb     in   psel/penable    ram_enable_key where paddr[2] is 0
//
// One access per cycle sustained while the output side keeps up with results.
// Each result passes the registered RAM read stage and then the output register.
// Registers and RAM are written at the accepting edge, so no forwarding is needed.
// A full output register that rsp_o does not take stalls the RAM stage, which then stalls the request side.
// Reset is asynchronous; cartridge RAM contents are undefined until written.
module cartridge_bank_mapper_unit import cbm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cbm_req_if.sink           req_i,
  cbm_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [BYTE_W-1:0]      key_q, key_d;
  logic [BYTE_W-1:0]      ram_en_q, ram_en_d;
  logic [LOW_BANK_W-1:0]  low_bank_q, low_bank_d;
  logic [HIGH_BANK_W-1:0] high_bank_q, high_bank_d;
  logic                   mode_q, mode_d;

  logic                   s1_valid_q;
  stage_t                 s1_q, s1_d;
  logic [BYTE_W-1:0]      rd_q;
  logic [BYTE_W-1:0]      cart_ram_mem [RAM_BYTES];

  logic                   out_valid_q;
  logic [BYTE_W-1:0]      out_byte_q;
  logic                   out_fetch_q;
  logic [ROM_ADDR_W-1:0]  out_addr_q;

  logic                   accept, s1_adv, ram_on, ram_we, is_write, cfg_wr;
  region_e                region;
  logic [RAM_AW-1:0]      ram_idx;
  logic [LOW_BANK_W-1:0]  low_wr;

  assign is_write = (op_e'(req_i.opcode) == OP_WRITE);
  assign region   = region_e'(req_i.bus_address[ADDR_W-1 -: 3]);
  assign ram_idx  = req_i.bus_address[RAM_AW-1:0];
  assign ram_on   = (ram_en_q == key_q);
  assign low_wr   = req_i.write_byte[LOW_BANK_W-1:0];

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;
  assign ram_we      = accept && is_write && (region == RGN_CART_RAM) && ram_on;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == CFG_KEY_IDX);
  assign prdata = (paddr[CFG_AW-1] == CFG_KEY_IDX) ? {{(CFG_DW-BYTE_W){1'b0}}, key_q}
                                                   : '0;
  assign key_d  = cfg_wr ? pwdata[BYTE_W-1:0] : key_q;

  // register writes
  always_comb begin
    ram_en_d    = ram_en_q;
    low_bank_d  = low_bank_q;
    high_bank_d = high_bank_q;
    mode_d      = mode_q;
    if (accept && is_write) begin
      unique case (region)
        RGN_RAM_ENABLE: ram_en_d = req_i.write_byte;
        RGN_LOW_BANK:   low_bank_d = (low_wr == '0) ? LOW_BANK_RESET : low_wr;
        RGN_HIGH_BANK: begin
          if (!mode_q) high_bank_d = req_i.write_byte[HIGH_BANK_W-1:0];
        end
        RGN_MODE:       mode_d = req_i.write_byte[0];
        default:        ;
      endcase
    end
  end

  // read decode
  always_comb begin
    s1_d        = '0;
    if (!is_write) begin
      if (!req_i.bus_address[ADDR_W-1]) begin
        s1_d.fetch = 1'b1;
        if (req_i.bus_address[OFFSET_W]) begin
          s1_d.rom_address = {high_bank_q, low_bank_q,
                              req_i.bus_address[OFFSET_W-1:0]};
        end else begin
          s1_d.rom_address = {{(ROM_ADDR_W-OFFSET_W){1'b0}},
                              req_i.bus_address[OFFSET_W-1:0]};
        end
      end else begin
        s1_d.ram_rd = (region == RGN_CART_RAM) && ram_on;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= KEY_RESET;
      ram_en_q    <= '0;
      low_bank_q  <= LOW_BANK_RESET;
      high_bank_q <= '0;
      mode_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      key_q       <= key_d;
      ram_en_q    <= ram_en_d;
      low_bank_q  <= low_bank_d;
      high_bank_q <= high_bank_d;
      mode_q      <= mode_d;
      if (req_i.ready) s1_valid_q <= accept;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) cart_ram_mem[ram_idx] <= req_i.write_byte;
    if (accept) begin
      rd_q <= cart_ram_mem[ram_idx];
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q  <= s1_q.ram_rd ? rd_q : OPEN_BUS;
      out_fetch_q <= s1_q.fetch;
      out_addr_q  <= s1_q.rom_address;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_byte   = out_byte_q;
  assign rsp_o.rom_fetch   = out_fetch_q;
  assign rsp_o.rom_address = out_addr_q;

  a_low_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_bank_q != '0) else $error("low bank reached zero");

  a_mode1_holds_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q |=> $stable(high_bank_q)) else $error("high bank changed in mode 1");

  a_fetch_open_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fetch_q) |-> (out_byte_q == OPEN_BUS))
    else $error("ROM fetch carries RAM data");

  a_nofetch_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_fetch_q) |-> (out_addr_q == '0))
    else $error("ROM address set without fetch");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q) else $error("accepted beat lost");

endmodule
